// ===== src/tsd_pkg.sv =====
// Shared types, constants and segment encoding for the three-digit display driver.
package tsd_pkg;

	// Field widths and packing
	localparam int MAG_W         = 21;
	localparam int SEG_W         = 8;
	localparam int COM_W         = 3;
	localparam int OP_W          = 2;
	localparam int DWELL_W       = 4;
	localparam int CFG_ADDR_W    = 1;
	localparam int CFG_DATA_W    = 4;
	localparam int RAW_L_LSB     = MAG_W;
	localparam int RAW_M_LSB     = RAW_L_LSB + SEG_W;
	localparam int RAW_R_LSB     = RAW_M_LSB + SEG_W;
	localparam int S_FIELDS_W    = RAW_R_LSB + SEG_W;
	localparam int S_TDATA_W     = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_FIELDS_W    = SEG_W + COM_W;
	localparam int M_TDATA_W     = ((M_FIELDS_W + 7) / 8) * 8;

	// Binary to BCD conversion
	localparam int BCD_DIGITS    = 7;
	localparam int BCD_W         = 4 * BCD_DIGITS;
	localparam int SHIFT_CNT_W   = $clog2(MAG_W + 1);
	localparam int DIGIT_IDX_W   = $clog2(BCD_DIGITS);

	// Command queue
	localparam int QUEUE_DEPTH   = 2;
	localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW      = $clog2(QUEUE_DEPTH + 1);

	// Register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_COMMON_ANODE = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_DWELL_TICKS  = 1'b1;

	// Segment codes, common-anode polarity
	localparam logic [SEG_W-1:0] DIGIT_CODES [10] = '{
		8'd3, 8'd159, 8'd37, 8'd13, 8'd153, 8'd73, 8'd65, 8'd31, 8'd1, 8'd9
	};
	localparam logic [SEG_W-1:0] MINUS_CODE = 8'd253;
	localparam logic [SEG_W-1:0] BLANK_CODE = 8'hFF;

	typedef enum logic [OP_W-1:0] {
		OP_TICK   = 2'd0,
		OP_NUMBER = 2'd1,
		OP_RAW    = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		PH_START  = 2'd0,
		PH_LEFT   = 2'd1,
		PH_MIDDLE = 2'd2,
		PH_RIGHT  = 2'd3
	} phase_t;

	typedef enum logic {
		BK_IDLE,
		BK_CONV
	} back_state_t;

	typedef struct packed {
		op_t              op;
		logic             neg;
		logic [MAG_W-1:0] mag;
		logic [SEG_W-1:0] raw_left;
		logic [SEG_W-1:0] raw_middle;
		logic [SEG_W-1:0] raw_right;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_push_t;

	typedef struct packed {
		logic [SEG_W-1:0] seg;
		logic [COM_W-1:0] com;
	} result_t;

	// Apply polarity to a common-anode code
	function automatic logic [SEG_W-1:0] seg_polar(logic [SEG_W-1:0] code, logic anode);
		return anode ? code : ~code;
	endfunction

	function automatic logic [SEG_W-1:0] seg_digit(logic [3:0] d, logic anode);
		logic [SEG_W-1:0] code;
		code = (d < 4'd10) ? DIGIT_CODES[d] : BLANK_CODE;
		return seg_polar(code, anode);
	endfunction

	// Decimal point lives in bit 0
	function automatic logic [SEG_W-1:0] seg_point(logic [SEG_W-1:0] b, logic anode);
		return anode ? (b & 8'hFE) : (b | 8'h01);
	endfunction

endpackage

// ===== src/tsd_bcd.sv =====
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
module tsd_bcd (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [tsd_pkg::MAG_W-1:0]             mag,
	output logic                                  done,
	output logic [tsd_pkg::BCD_DIGITS-1:0][3:0]   digits
);
	import tsd_pkg::*;

	logic [MAG_W-1:0]       shift_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [BCD_W-1:0]       adj;
	logic [SHIFT_CNT_W-1:0] cnt_q;
	logic                   done_q;

	always_comb begin
		for (int k = 0; k < BCD_DIGITS; k++) begin
			adj[4*k +: 4] = (bcd_q[4*k +: 4] >= 4'd5) ? bcd_q[4*k +: 4] + 4'd3
			                                         : bcd_q[4*k +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= SHIFT_CNT_W'(MAG_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - SHIFT_CNT_W'(1);
			if (cnt_q == SHIFT_CNT_W'(1)) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= mag;
			bcd_q   <= '0;
		end else if (cnt_q != '0) begin
			shift_q <= {shift_q[MAG_W-2:0], 1'b0};
			bcd_q   <= {adj[BCD_W-2:0], shift_q[MAG_W-1]};
		end
	end

	assign done   = done_q;
	assign digits = bcd_q;

endmodule

// ===== src/tsd_front.sv =====
// Input stage: accepts transactions, decodes the op and takes the value's magnitude.
module tsd_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [tsd_pkg::S_TDATA_W-1:0]     s_tdata,
	input  logic [tsd_pkg::OP_W-1:0]          s_tuser,
	output tsd_pkg::cmd_push_t                push,
	input  logic                              push_ready
);
	import tsd_pkg::*;

	logic             valid_s1;
	cmd_t             cmd_s1;
	cmd_t             dec;
	logic [MAG_W-1:0] value;
	logic             accept;

	always_comb begin
		value          = s_tdata[MAG_W-1:0];
		dec.op         = op_t'(s_tuser);
		dec.neg        = value[MAG_W-1];
		// two's complement magnitude; the most negative code maps onto itself
		dec.mag        = value[MAG_W-1] ? (~value + MAG_W'(1)) : value;
		dec.raw_left   = s_tdata[RAW_L_LSB +: SEG_W];
		dec.raw_middle = s_tdata[RAW_M_LSB +: SEG_W];
		dec.raw_right  = s_tdata[RAW_R_LSB +: SEG_W];
	end

	assign s_tready = !valid_s1 || push_ready;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= dec;
		end
	end

	assign push.valid = valid_s1;
	assign push.cmd   = cmd_s1;

endmodule

// ===== src/tsd_queue.sv =====
// Small command FIFO between the input stage and the execution stage.
module tsd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  tsd_pkg::cmd_push_t  push,
	output logic                push_ready,
	input  logic                pop,
	output tsd_pkg::cmd_t       head,
	output logic                head_valid
);
	import tsd_pkg::*;

	cmd_t                entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	function automatic logic [QUEUE_AW-1:0] ptr_inc(logic [QUEUE_AW-1:0] p);
		return (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_AW'(1);
	endfunction

	assign push_ready = (count_q != QUEUE_CW'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign do_push    = push.valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QUEUE_CW'(1);
				2'b01:   count_q <= count_q - QUEUE_CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.cmd;
		end
	end

endmodule

// ===== src/tsd_back.sv =====
// Execution stage: digit store, scan sequencer, number formatting and result register.
module tsd_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tsd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [tsd_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  tsd_pkg::cmd_t                     head,
	input  logic                              head_valid,
	output logic                              pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output tsd_pkg::result_t                  result
);
	import tsd_pkg::*;

	localparam logic [COM_W-1:0] LIT_LEFT   = 3'b001;
	localparam logic [COM_W-1:0] LIT_MIDDLE = 3'b010;
	localparam logic [COM_W-1:0] LIT_RIGHT  = 3'b100;

	// configuration
	logic               anode_q;
	logic [DWELL_W-1:0] dwell_q;

	// display state; index 2 is the left digit
	logic [2:0][SEG_W-1:0] digits_q;
	phase_t                phase_q;
	logic [DWELL_W-1:0]    count_q;
	logic [COM_W-1:0]      lit_q;
	logic [SEG_W-1:0]      seg_q;

	back_state_t state_q, state_n;
	logic        neg_q;
	logic        out_valid_q;
	result_t     out_q;
	logic        out_free;
	logic        bcd_start;
	logic        bcd_done;
	logic        emit_op;
	logic        emit_num;

	logic [BCD_DIGITS-1:0][3:0] bcd_digits;

	// tick results
	phase_t             ph_n;
	logic [DWELL_W-1:0] cnt_n;
	logic [COM_W-1:0]   lit_n;
	logic [SEG_W-1:0]   seg_n;

	// number formatting
	logic [DIGIT_IDX_W-1:0] top;
	logic [SEG_W-1:0]       fmt_left, fmt_middle, fmt_right;
	logic                   pt_left, pt_middle;
	logic [SEG_W-1:0]       fill;
	result_t                res;

	tsd_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bcd_start),
		.mag    (head.mag),
		.done   (bcd_done),
		.digits (bcd_digits)
	);

	assign out_free = !out_valid_q || m_tready;

	// sequencer: next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			BK_IDLE: if (head_valid && head.op == OP_NUMBER) state_n = BK_CONV;
			BK_CONV: if (bcd_done && out_free) state_n = BK_IDLE;
			default: state_n = BK_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		bcd_start = 1'b0;
		emit_op   = 1'b0;
		emit_num  = 1'b0;
		case (state_q)
			BK_IDLE: begin
				bcd_start = head_valid && head.op == OP_NUMBER;
				emit_op   = head_valid && head.op != OP_NUMBER && out_free;
			end
			BK_CONV: begin
				emit_num = bcd_done && out_free;
			end
			default: ;
		endcase
	end

	assign pop = bcd_start || emit_op;

	// one tick, with phase steps cascading in order
	always_comb begin
		ph_n  = phase_q;
		cnt_n = count_q;
		lit_n = lit_q;
		seg_n = seg_q;
		if (ph_n == PH_START) begin
			lit_n = lit_n | LIT_LEFT;
			seg_n = digits_q[2];
			ph_n  = PH_LEFT;
		end
		if (ph_n == PH_LEFT) begin
			cnt_n = cnt_n + DWELL_W'(1);
			if (cnt_n >= dwell_q) begin
				cnt_n = '0;
				lit_n = (lit_n & ~LIT_LEFT) | LIT_MIDDLE;
				seg_n = digits_q[1];
				ph_n  = PH_MIDDLE;
			end
		end
		if (ph_n == PH_MIDDLE) begin
			cnt_n = cnt_n + DWELL_W'(1);
			if (cnt_n >= dwell_q) begin
				cnt_n = '0;
				lit_n = (lit_n & ~LIT_MIDDLE) | LIT_RIGHT;
				seg_n = digits_q[0];
				ph_n  = PH_RIGHT;
			end
		end
		if (ph_n == PH_RIGHT) begin
			cnt_n = cnt_n + DWELL_W'(1);
			if (cnt_n >= dwell_q) begin
				cnt_n = '0;
				lit_n = lit_n & ~LIT_RIGHT;
				ph_n  = PH_START;
			end
		end
	end

	// leading integer digit: position 2 is the units digit
	always_comb begin
		if (bcd_digits[6] != 4'd0)      top = 3'd6;
		else if (bcd_digits[5] != 4'd0) top = 3'd5;
		else if (bcd_digits[4] != 4'd0) top = 3'd4;
		else if (bcd_digits[3] != 4'd0) top = 3'd3;
		else                            top = 3'd2;
	end

	always_comb begin
		pt_left   = !neg_q && top == 3'd2;
		pt_middle = (neg_q && top == 3'd2) || (!neg_q && top == 3'd3);
		if (neg_q) begin
			fmt_left   = seg_polar(MINUS_CODE, anode_q);
			fmt_middle = seg_digit(bcd_digits[top], anode_q);
			fmt_right  = seg_digit(bcd_digits[top - 3'd1], anode_q);
		end else begin
			fmt_left   = seg_digit(bcd_digits[top], anode_q);
			fmt_middle = seg_digit(bcd_digits[top - 3'd1], anode_q);
			fmt_right  = seg_digit(bcd_digits[top - 3'd2], anode_q);
		end
		if (pt_left) fmt_left = seg_point(fmt_left, anode_q);
		if (pt_middle) fmt_middle = seg_point(fmt_middle, anode_q);
	end

	assign fill = seg_polar(BLANK_CODE, anode_q);

	always_comb begin
		if (emit_op && head.op == OP_TICK) begin
			res.seg = seg_n;
			res.com = anode_q ? lit_n : ~lit_n;
		end else begin
			res.seg = seg_q;
			res.com = anode_q ? lit_q : ~lit_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anode_q     <= 1'b1;
			dwell_q     <= DWELL_W'(3);
			digits_q    <= '0;
			phase_q     <= PH_START;
			count_q     <= '0;
			lit_q       <= '0;
			seg_q       <= '0;
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_COMMON_ANODE: anode_q <= cfg_data[0];
					REG_DWELL_TICKS:  dwell_q <= cfg_data;
					default: ;
				endcase
			end
			state_q <= state_n;
			if (emit_op) begin
				case (head.op)
					OP_TICK: begin
						phase_q <= ph_n;
						count_q <= cnt_n;
						lit_q   <= lit_n;
						seg_q   <= seg_n;
					end
					OP_RAW:   digits_q <= {head.raw_left, head.raw_middle, head.raw_right};
					OP_CLEAR: digits_q <= {fill, fill, fill};
					default: ;
				endcase
			end
			if (emit_num) begin
				digits_q <= {fmt_left, fmt_middle, fmt_right};
			end
			if (emit_op || emit_num) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bcd_start) begin
			neg_q <= head.neg;
		end
		if (emit_op || emit_num) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign result   = out_q;

endmodule

// ===== src/three_digit_seven_segment_driver.sv =====
// Top level of the three-digit multiplexed seven-segment display driver.
//
// Input stream (s_*): one transaction per command. s_tuser carries the op
// (tick, write number, write raw segments, clear); s_tdata carries the value
// in hundredths and three raw segment bytes. Every command yields exactly one
// output transaction (m_*) with the segment and common pin levels as they
// stand after the command. Only ticks move the pins; writes change the stored
// digit bytes that later ticks put on the pins.
// Path: tick, raw write and clear go from input to output through the input
// register, the queue and the result register. A number write also goes
// through the bit-serial binary to BCD converter, one bit per cycle over the
// 21-bit magnitude; the converter handles one number at a time.
// Up to three commands sit in the input register and queue, so the input
// keeps accepting while a result waits on m_tready; once those are full,
// s_tready drops until the receiver takes the pending result.
// Configuration: cfg_we writes cfg_data into register cfg_addr (0 polarity,
// 1 dwell ticks) in the same edge; write only while no command is in flight.
// Reset: all digit bytes zero, scan at its start, commons inactive, common
// anode polarity with the dwell ticks register at 3.
module three_digit_seven_segment_driver (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tsd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [tsd_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// s_tdata: value[20:0], raw_left[28:21], raw_middle[36:29], raw_right[44:37]
	input  logic [tsd_pkg::S_TDATA_W-1:0]     s_tdata,
	// s_tuser: op[1:0]
	input  logic [tsd_pkg::OP_W-1:0]          s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// m_tdata: segment_pins[7:0], common_pins[10:8]
	output logic [tsd_pkg::M_TDATA_W-1:0]     m_tdata
);
	import tsd_pkg::*;

	cmd_push_t push;
	logic      push_ready;
	cmd_t      head;
	logic      head_valid;
	logic      pop;
	result_t   result;

	tsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push       (push),
		.push_ready (push_ready)
	);

	// decouples command intake from execution
	tsd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	tsd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_data   (cfg_data),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.result     (result)
	);

	// pack result, zero pad to whole bytes
	assign m_tdata = {(M_TDATA_W - M_FIELDS_W)'(0), result.com, result.seg};

endmodule

// ===== src/tsd_checker.sv =====
// Port-level assertions for the display driver, bound to the top level.
module tsd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [tsd_pkg::M_TDATA_W-1:0] m_tdata
);
	import tsd_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output data changed while stalled");

	// at most one common line at its lit level, whatever the polarity
	a_one_lit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($onehot0(m_tdata[M_FIELDS_W-1:SEG_W])
		           || $onehot0(~m_tdata[M_FIELDS_W-1:SEG_W])))
		else $error("more than one digit lit");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[M_TDATA_W-1:M_FIELDS_W] == '0)
		else $error("output padding not zero");

endmodule

bind three_digit_seven_segment_driver tsd_checker u_tsd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
